@@ hw/rtl/morse_decoder_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Morse decoder assertion macros
// Shared concurrent assertion wrappers, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef MORSE_DECODER_UNIT_MACROS_SVH
`define MORSE_DECODER_UNIT_MACROS_SVH

// Invariant that must hold at every edge out of reset.
`define MDU_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Condition at one edge implies a consequence at the next edge.
`define MDU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/morse_pkg.sv @@
// ----------------------------------------------------------------------------
// Morse decoder package
// Symbol codes, result codes and the code-to-letter lookup.
// ----------------------------------------------------------------------------
package morse_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned BITS_W = 4;
    localparam int unsigned LEN_W  = 3;

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [BITS_W-1:0] t_code_bits;
    typedef logic [LEN_W-1:0]  t_code_len;

    // input symbols
    localparam t_char SYM_DOT  = 8'h2E;
    localparam t_char SYM_DASH = 8'h2D;
    localparam t_char SYM_SEP  = 8'h20;
    localparam t_char SYM_END  = 8'h00;

    // result letters
    localparam t_char LETTER_UNKNOWN = 8'h3F;
    localparam t_char LETTER_NONE    = 8'h00;

    localparam t_code_len MAX_CODE = 3'd4;
    localparam t_code_len LEN_SAT  = 3'd5;

    // Pattern is first symbol most significant, dash = 1.
    function automatic t_char lookup_letter(input t_code_len  len,
                                            input t_code_bits bits,
                                            input logic       bad);
        t_char res;
        res = LETTER_UNKNOWN;
        if (!bad) begin
            case (len)
                3'd1: res = bits[0] ? "T" : "E";
                3'd2: begin
                    case (bits[1:0])
                        2'd0:    res = "I";
                        2'd1:    res = "A";
                        2'd2:    res = "N";
                        default: res = "M";
                    endcase
                end
                3'd3: begin
                    case (bits[2:0])
                        3'd0:    res = "S";
                        3'd1:    res = "U";
                        3'd2:    res = "R";
                        3'd3:    res = "W";
                        3'd4:    res = "D";
                        3'd5:    res = "K";
                        3'd6:    res = "G";
                        default: res = "O";
                    endcase
                end
                3'd4: begin
                    case (bits)
                        4'd0:    res = "H";
                        4'd1:    res = "V";
                        4'd2:    res = "F";
                        4'd4:    res = "L";
                        4'd6:    res = "P";
                        4'd7:    res = "J";
                        4'd8:    res = "B";
                        4'd9:    res = "X";
                        4'd10:   res = "C";
                        4'd11:   res = "Y";
                        4'd12:   res = "Z";
                        4'd13:   res = "Q";
                        4'd15:   res = " ";
                        default: res = LETTER_UNKNOWN;
                    endcase
                end
                default: res = LETTER_UNKNOWN;
            endcase
        end
        return res;
    endfunction

endpackage

@@ hw/rtl/morse_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// Morse decoder unit
// Turns a stream of '.', '-', ' ' and end bytes into decoded ASCII letters.
// ----------------------------------------------------------------------------
//  channel   dir  tdata              tuser  tlast
//  s_axis    in   [7:0] character    -      -
//  m_axis    out  [7:0] letter       -      message_end
//
//  One item per cycle while s_axis_tready is high; the letter lookup reads
//  the registered code combinationally, ahead of the output register.
//  A result appears in the cycle after its item is accepted.
//  s_axis_tready drops only while a result waits and m_axis_tready is low.
//  Synchronous active-low reset clears the pending code and the output valid.
// ----------------------------------------------------------------------------
`include "morse_decoder_unit_macros.svh"

module morse_decoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] character
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] letter
    output logic       m_axis_tlast    // message_end
);

    morse_pkg::t_code_bits r_code_bits, n_code_bits;
    morse_pkg::t_code_len  r_code_len,  n_code_len;
    logic                  r_bad,       n_bad;
    logic                  r_out_valid;
    morse_pkg::t_char      r_letter,    n_letter;
    logic                  r_last;

    logic s_acc;
    logic pending;
    logic emit;
    logic is_dot, is_dash, is_sep, is_end, is_sym;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    assign is_dot  = (s_axis_tdata == morse_pkg::SYM_DOT);
    assign is_dash = (s_axis_tdata == morse_pkg::SYM_DASH);
    assign is_sep  = (s_axis_tdata == morse_pkg::SYM_SEP);
    assign is_end  = (s_axis_tdata == morse_pkg::SYM_END);
    assign is_sym  = !is_sep && !is_end;  // dot, dash, or bad byte

    assign pending = (r_code_len != '0) || r_bad;
    assign emit    = is_end || (is_sep && pending);

    always_comb begin
        n_code_bits = r_code_bits;
        n_code_len  = r_code_len;
        n_bad       = r_bad;
        if (is_sym) begin
            if (r_code_len < morse_pkg::MAX_CODE) begin
                n_code_bits = {r_code_bits[morse_pkg::BITS_W-2:0], is_dash};
            end
            if (r_code_len < morse_pkg::LEN_SAT) begin
                n_code_len = r_code_len + 3'd1;
            end
            if (!is_dot && !is_dash) begin
                n_bad = 1'b1;
            end
        end else begin
            // separator or end byte clears the code
            n_code_bits = '0;
            n_code_len  = '0;
            n_bad       = 1'b0;
        end
    end

    always_comb begin
        if (pending) begin
            n_letter = morse_pkg::lookup_letter(r_code_len, r_code_bits, r_bad);
        end else begin
            n_letter = morse_pkg::LETTER_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_bits <= '0;
            r_code_len  <= '0;
            r_bad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_acc) begin
                r_code_bits <= n_code_bits;
                r_code_len  <= n_code_len;
                r_bad       <= n_bad;
            end
            if (s_axis_tready) begin
                r_out_valid <= s_acc && emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc && emit) begin
            r_letter <= n_letter;
            r_last   <= is_end;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_letter;
    assign m_axis_tlast  = r_last;

    `MDU_ASSERT_ALWAYS(a_len_sat, (r_code_len <= morse_pkg::LEN_SAT), "code length past saturation")
    `MDU_ASSERT_NEXT(a_end_flush, (s_acc && is_end), (m_axis_tvalid && m_axis_tlast && r_code_len == '0 && !r_bad), "end byte did not flush")
    `MDU_ASSERT_NEXT(a_sym_count, (s_acc && is_sym && r_code_len < morse_pkg::LEN_SAT), (r_code_len == $past(r_code_len) + 3'd1 && !m_axis_tvalid), "symbol not counted")

endmodule
